### rtl/salru_pkg.sv
// salru_pkg: shared types and constants of the true lru replacement block
// no dependencies; used by salru_age_unit and set_assoc_lru_replacement

package salru_pkg;

	// operation codes on the op field
	localparam logic OP_VICTIM = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	// fixed field widths of the access and result transfers
	localparam int SET_IN_W = 11;
	localparam int WAY_IN_W = 4;

	typedef logic [WAY_IN_W-1:0] way_field_t;

	// result of the age logic for one access
	typedef struct packed {
		logic       way_ok;
		way_field_t victim;
	} age_info_t;

endpackage

### rtl/salru_ram.sv
// salru_ram: generic single-clock ram, one write and one read port, registered read
// no dependencies

module salru_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/salru_age_unit.sv
// salru_age_unit: victim search and age update over one row of way ages
// depends on salru_pkg

module salru_age_unit #(
	parameter int NUM_WAYS = 16
) (
	input  logic [NUM_WAYS*$clog2(NUM_WAYS)-1:0] row,
	input  salru_pkg::way_field_t                way_index,
	output logic [NUM_WAYS*$clog2(NUM_WAYS)-1:0] new_row,
	output salru_pkg::age_info_t                 info
);

	localparam int AGE_W = $clog2(NUM_WAYS);
	localparam logic [AGE_W-1:0] OLDEST = AGE_W'(NUM_WAYS - 1);

	logic [NUM_WAYS-1:0] hit;
	logic [AGE_W-1:0]    touched;

	// one-hot select of the touched way
	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			hit[w] = (32'(way_index) == 32'(w));
		end
	end

	always_comb begin
		touched = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			touched = touched | (row[w*AGE_W +: AGE_W] & {AGE_W{hit[w]}});
		end
	end

	// younger ways age by one, touched way becomes most recent
	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (hit[w]) begin
				new_row[w*AGE_W +: AGE_W] = '0;
			end else if (row[w*AGE_W +: AGE_W] < touched) begin
				new_row[w*AGE_W +: AGE_W] = row[w*AGE_W +: AGE_W] + AGE_W'(1);
			end else begin
				new_row[w*AGE_W +: AGE_W] = row[w*AGE_W +: AGE_W];
			end
		end
	end

	// lowest way holding the oldest age, way 0 if none
	always_comb begin
		info.victim = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (row[w*AGE_W +: AGE_W] == OLDEST) begin
				info.victim = salru_pkg::WAY_IN_W'(w);
			end
		end
		info.way_ok = (32'(way_index) < 32'(NUM_WAYS));
	end

endmodule

### rtl/set_assoc_lru_replacement.sv
// set_assoc_lru_replacement: true lru replacement, one age per way held in a ram row per set
// path: a victim query passes s1, s2 and the result register before victim_way shows it
// throughput: one access per cycle while req_stall is low, bounded by the single read-modify-write of the age ram
// reset: a clearing pass writes ages 0..NUM_WAYS-1 to every set,
// req_stall stays high until it is done
// depends on salru_pkg, salru_ram, salru_age_unit

module set_assoc_lru_replacement #(
	parameter int NUM_SETS = 2048,
	parameter int NUM_WAYS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// access channel
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic                                 op,
	input  logic [salru_pkg::SET_IN_W-1:0]       set_index,
	input  logic [salru_pkg::WAY_IN_W-1:0]       way_index,
	// victim channel
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic [salru_pkg::WAY_IN_W-1:0]       victim_way
);

	localparam int AGE_W = $clog2(NUM_WAYS);
	localparam int ROW_W = NUM_WAYS * AGE_W;
	localparam int AW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

	// pipeline: s1 holds the accepted access and issues the ram read,
	// s2 gets the row, applies forwarding, computes and writes back
	logic                               valid_s1;
	logic                               op_s1;
	logic [salru_pkg::SET_IN_W-1:0]     set_raw_s1;
	logic [salru_pkg::WAY_IN_W-1:0]     way_s1;
	logic [AW-1:0]                      set_addr;

	logic                               valid_s2;
	logic                               op_s2;
	logic [salru_pkg::WAY_IN_W-1:0]     way_s2;
	logic [AW-1:0]                      set_s2;

	// clearing sweep after reset
	logic                               clr_busy_q;
	logic [AW-1:0]                      clr_addr_q;
	logic [ROW_W-1:0]                   init_row;

	// most recent write-back, covers a read that raced a write to the same set
	logic                               fwd_valid_q;
	logic [AW-1:0]                      fwd_set_q;
	logic [ROW_W-1:0]                   fwd_row_q;

	logic                               out_valid_q;
	logic [salru_pkg::WAY_IN_W-1:0]     victim_q;

	logic [ROW_W-1:0]                   rd_row;
	logic [ROW_W-1:0]                   cur_row;
	logic [ROW_W-1:0]                   upd_row;
	salru_pkg::age_info_t               info;

	logic                               accept;
	logic                               s2_hold;
	logic                               s2_fire;
	logic                               row_wr;
	logic                               ram_we;
	logic [AW-1:0]                      ram_waddr;
	logic [ROW_W-1:0]                   ram_wdata;

	// ---------------------------------------------------------------
	// handshakes
	// ---------------------------------------------------------------
	// s2 only waits when it holds a victim query and the result register
	// is still full and stalled; updates and bubbles always move on
	assign s2_hold   = valid_s2 && (op_s2 == salru_pkg::OP_VICTIM) && out_valid_q && rsp_stall;
	assign s2_fire   = valid_s2 && !s2_hold;
	assign req_stall = clr_busy_q || (valid_s1 && s2_hold);
	assign accept    = req_valid && !req_stall;

	assign rsp_valid  = out_valid_q;
	assign victim_way = victim_q;

	// ---------------------------------------------------------------
	// set index reduction modulo NUM_SETS
	// ---------------------------------------------------------------
	generate
		if (NUM_SETS >= (1 << salru_pkg::SET_IN_W)) begin : g_set_direct
			// every set index is already in range
			assign set_addr = AW'(set_raw_s1);
		end else begin : g_set_mod
			// quotient by reciprocal multiply at accept, exact for 11-bit inputs,
			// remainder by one constant multiply and subtract in s1
			localparam int QK   = salru_pkg::SET_IN_W + $clog2(NUM_SETS);
			localparam int PW   = salru_pkg::SET_IN_W + QK + 1;
			localparam longint RECIP = ((longint'(1) << QK) + NUM_SETS - 1) / NUM_SETS;

			logic [PW-1:0]                  prod;
			logic [salru_pkg::SET_IN_W-1:0] q_s1;
			logic [salru_pkg::SET_IN_W-1:0] rem;

			assign prod = PW'(set_index) * PW'(RECIP);
			assign rem  = set_raw_s1
				- salru_pkg::SET_IN_W'(q_s1 * salru_pkg::SET_IN_W'(NUM_SETS));
			assign set_addr = rem[AW-1:0];

			always_ff @(posedge clk) begin
				if (accept) begin
					q_s1 <= prod[QK +: salru_pkg::SET_IN_W];
				end
			end
		end
	endgenerate

	// ---------------------------------------------------------------
	// stage 1: accepted access, ram read issued on the move to s2
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!s2_hold) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= op;
			set_raw_s1 <= set_index;
			way_s1     <= way_index;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: row in hand, compute and write back
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!s2_hold) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!s2_hold) begin
			op_s2  <= op_s1;
			way_s2 <= way_s1;
			set_s2 <= set_addr;
		end
	end

	// the forward register always holds the latest committed row, so a
	// match is correct even when the ram already has the same data
	assign cur_row = (fwd_valid_q && (fwd_set_q == set_s2)) ? fwd_row_q : rd_row;

	salru_age_unit #(
		.NUM_WAYS (NUM_WAYS)
	) u_age (
		.row       (cur_row),
		.way_index (way_s2),
		.new_row   (upd_row),
		.info      (info)
	);

	// an update to a way beyond NUM_WAYS leaves the set untouched
	assign row_wr = s2_fire && (op_s2 == salru_pkg::OP_UPDATE) && info.way_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (row_wr) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (row_wr) begin
			fwd_set_q <= set_s2;
			fwd_row_q <= upd_row;
		end
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_fire && (op_s2 == salru_pkg::OP_VICTIM)) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire && (op_s2 == salru_pkg::OP_VICTIM)) begin
			victim_q <= info.victim;
		end
	end

	// ---------------------------------------------------------------
	// clearing sweep: way j of every set gets age j
	// ---------------------------------------------------------------
	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			init_row[w*AGE_W +: AGE_W] = AGE_W'(w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(NUM_SETS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// age ram, one row per set
	// ---------------------------------------------------------------
	assign ram_we    = clr_busy_q || row_wr;
	assign ram_waddr = clr_busy_q ? clr_addr_q : set_s2;
	assign ram_wdata = clr_busy_q ? init_row : upd_row;

	salru_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_ages (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (valid_s1 && !s2_hold),
		.raddr (set_addr),
		.rdata (rd_row)
	);

endmodule

### tb/lru_victim_checker.sv
// lru_victim_checker: watches the access and victim channels, keeps its own age table and
// compares every victim_way transfer against the oldest predicted victim
// depends on salru_pkg for the op codes and the way field type

module lru_victim_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic                           req_stall,
	input  logic                           op,
	input  logic [salru_pkg::SET_IN_W-1:0] set_index,
	input  logic [salru_pkg::WAY_IN_W-1:0] way_index,
	input  logic                           rsp_valid,
	input  logic                           rsp_stall,
	input  logic [salru_pkg::WAY_IN_W-1:0] victim_way,
	output int                             errors,
	output int                             pending
);

	import salru_pkg::*;

	localparam int SETS = 2048;
	localparam int WAYS = 16;

	logic [WAY_IN_W-1:0] lru_ages [SETS][WAYS];
	way_field_t          victim_queue [$];
	way_field_t          expected_victim;
	int                  mismatches;

	// first way holding the oldest age, way 0 when none does
	function automatic way_field_t oldest_way(input int s);
		way_field_t v = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (lru_ages[s][w] == WAY_IN_W'(WAYS - 1)) begin
				v = way_field_t'(w);
			end
		end
		return v;
	endfunction

	// younger ways age by one, touched way becomes most recent
	function automatic void touch_way(input int s, input int w);
		logic [WAY_IN_W-1:0] touched = lru_ages[s][w];
		for (int i = 0; i < WAYS; i++) begin
			if (lru_ages[s][i] < touched) begin
				lru_ages[s][i] = lru_ages[s][i] + 1'b1;
			end
		end
		lru_ages[s][w] = '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) begin
				for (int w = 0; w < WAYS; w++) begin
					lru_ages[s][w] = WAY_IN_W'(w);
				end
			end
			victim_queue.delete();
			mismatches = 0;
		end else begin
			// results first, so a query accepted on this edge is not matched yet
			if (rsp_valid && !rsp_stall) begin
				if (victim_queue.size() == 0) begin
					mismatches++;
					$display("%0t: victim_way transfer, expected none, actual %0d",
						$time, victim_way);
				end else begin
					expected_victim = victim_queue.pop_front();
					if (victim_way !== expected_victim) begin
						mismatches++;
						$display("%0t: victim_way mismatch, expected %0d, actual %0d",
							$time, expected_victim, victim_way);
					end
				end
			end
			if (req_valid && !req_stall) begin
				if (op == OP_VICTIM) begin
					victim_queue.push_back(oldest_way(int'(set_index) % SETS));
				end else if (int'(way_index) < WAYS) begin
					touch_way(int'(set_index) % SETS, int'(way_index));
				end
			end
		end
		errors  <= mismatches;
		pending <= victim_queue.size();
	end

endmodule

### tb/set_assoc_lru_replacement_test.sv
// set_assoc_lru_replacement_test: stimulus, idling and verdict for the true lru block
// depends on salru_pkg, the block itself and lru_victim_checker

module set_assoc_lru_replacement_test;

	import salru_pkg::*;

	localparam int HALF_PERIOD     = 6;
	localparam int IDLE_LIMIT      = 20000; // covers the clearing pass and the long hold-off
	localparam int HOLD_CYCLES     = 400;
	localparam int PHASE_ITEMS     = 380;
	localparam int HOLD_ITEMS      = 64;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOT_SETS        = 8;
	localparam int HOT_W           = $clog2(HOT_SETS);

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                op        = OP_VICTIM;
	logic [SET_IN_W-1:0] set_index = '0;
	way_field_t          way_index = '0;
	logic                rsp_stall = 1'b0;
	logic                req_stall;
	logic                rsp_valid;
	way_field_t          victim_way;

	int fail_count;
	int victims_pending;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	bit hold_request  = 1'b0;
	int idle_cycles   = 0;

	// small pool of sets so the ages get well shuffled
	logic [SET_IN_W-1:0] hot_sets [HOT_SETS];

	always #HALF_PERIOD clk = ~clk;

	set_assoc_lru_replacement dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.op         (op),
		.set_index  (set_index),
		.way_index  (way_index),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.victim_way (victim_way)
	);

	lru_victim_checker victim_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.op         (op),
		.set_index  (set_index),
		.way_index  (way_index),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.victim_way (victim_way),
		.errors     (fail_count),
		.pending    (victims_pending)
	);

	// one access transfer; entered and left at a falling edge
	task automatic send_access(input logic o, input logic [SET_IN_W-1:0] s, input way_field_t w);
		// random gap before the item, valid low while idle
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		op        <= o;
		set_index <= s;
		way_index <= w;
		// payload held until the transfer happens
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic send_random_access();
		logic [SET_IN_W-1:0] s;
		if ($urandom_range(99) < 80) begin
			s = hot_sets[HOT_W'($urandom_range(HOT_SETS - 1))];
		end else begin
			s = SET_IN_W'($urandom_range(2047));
		end
		send_access($urandom_range(1) ? OP_UPDATE : OP_VICTIM, s,
			way_field_t'($urandom_range(15)));
	endtask

	task automatic pick_hot_sets();
		hot_sets[0] = '0;
		hot_sets[1] = '1;
		for (int i = 2; i < HOT_SETS; i++) begin
			hot_sets[i] = SET_IN_W'($urandom_range(2047));
		end
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		pick_hot_sets();
		repeat (PHASE_ITEMS) send_random_access();
	endtask

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, no idling; block still busy clearing, so the first item waits
		// fresh sets report the top way as victim, query ignores its way field
		send_access(OP_VICTIM, 11'd0, 4'd0);
		send_access(OP_VICTIM, 11'h7ff, 4'd15);
		// touch the oldest way and query straight after, same set back to back
		send_access(OP_UPDATE, 11'd0, 4'd15);
		send_access(OP_VICTIM, 11'd0, 4'd0);
		// touching way 0 twice; the second touch, of the most recent way, leaves the order unchanged
		send_access(OP_UPDATE, 11'd0, 4'd0);
		send_access(OP_UPDATE, 11'd0, 4'd0);
		send_access(OP_VICTIM, 11'd0, 4'd15);
		send_access(OP_UPDATE, 11'h7ff, 4'd14);
		send_access(OP_UPDATE, 11'h7ff, 4'd15);
		send_access(OP_VICTIM, 11'h7ff, 4'd0);
		send_access(OP_UPDATE, 11'h400, 4'd0);
		send_access(OP_VICTIM, 11'h400, 4'd0);
		// walk the upper ways so the victim moves down to way 7
		for (int w = 15; w >= 8; w--) begin
			send_access(OP_UPDATE, 11'h2aa, way_field_t'(w));
		end
		send_access(OP_VICTIM, 11'h2aa, 4'd15);
		send_access(OP_VICTIM, 11'h555, 4'd15);

		// random phases over the idling mixes
		run_phase(0, 0);
		run_phase(56, 0);
		run_phase(0, 56);
		run_phase(9, 9);

		// long receiver hold-off with a steady stream of queries, block fills and stalls
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		pick_hot_sets();
		hold_request = 1'b1;
		repeat (HOLD_ITEMS) begin
			send_access(OP_VICTIM, hot_sets[HOT_W'($urandom_range(HOT_SETS - 1))],
				way_field_t'($urandom_range(15)));
		end
		repeat (HOLD_ITEMS) send_random_access();

		req_valid <= 1'b0;
		while (victims_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
